### rtl/pstg_pkg.sv
// Package with the word types, constants and lookup functions of the P-state table generator.
`timescale 1ns / 1ps
package pstg_pkg;

    localparam int MAX_STATES = 32;
    localparam int CNT_W = $clog2(MAX_STATES + 1);
    localparam int NUM_W = 51;
    localparam int DEN_W = 35;
    localparam int MUL_A_W = 41;
    localparam int MUL_B_W = 13;
    localparam int POWER_W = 20;

    localparam logic [7:0] SOCKET_RESET = 8'h11;
    localparam logic [5:0] SPECIAL_FID = 6'h2A;
    localparam logic [5:0] SPECIAL_MIN_FID = 6'd2;
    localparam logic [31:0] CTRL_FIXED = 32'hE8202800;
    localparam logic [POWER_W-1:0] POWER_MAX = '1;

    typedef struct packed {
        logic [1:0] core_cap;
        logic [3:0] power_code;
        logic       states_valid;
        logic       intermediate_ok;
        logic [5:0] max_fid;
        logic [5:0] low_fid;
        logic [5:0] max_vid;
        logic [5:0] low_vid;
        logic       vid_step;
    } req_word_t;

    typedef struct packed {
        logic [4:0]  state_index;
        logic [5:0]  fid_out;
        logic [12:0] freq_mhz;
        logic [6:0]  vid_out;
        logic [19:0] power_mw;
        logic [31:0] control_word;
        logic [12:0] status_word;
        logic        empty_res;
        logic        last;
    } rsp_word_t;

    typedef struct packed {
        logic [7:0] sock;
        logic [1:0] cores;
        logic [3:0] code;
        logic [6:0] watts;
    } limit_row_t;

    localparam limit_row_t LIMIT_TABLE [20] = '{
        '{8'h11, 2'd0, 4'h8, 7'd62},  '{8'h11, 2'd1, 4'h8, 7'd89},
        '{8'h11, 2'd1, 4'ha, 7'd103}, '{8'h11, 2'd1, 4'hc, 7'd125},
        '{8'h11, 2'd0, 4'h2, 7'd15},  '{8'h11, 2'd0, 4'h4, 7'd35},
        '{8'h11, 2'd1, 4'h2, 7'd35},  '{8'h11, 2'd0, 4'h5, 7'd45},
        '{8'h11, 2'd1, 4'h7, 7'd76},  '{8'h11, 2'd1, 4'h6, 7'd65},
        '{8'h11, 2'd1, 4'h8, 7'd89},  '{8'h11, 2'd0, 4'h1, 7'd8},
        '{8'h11, 2'd1, 4'h1, 7'd22},  '{8'h12, 2'd0, 4'h6, 7'd25},
        '{8'h12, 2'd0, 4'h1, 7'd8},   '{8'h12, 2'd0, 4'h2, 7'd9},
        '{8'h12, 2'd0, 4'h4, 7'd15},  '{8'h12, 2'd0, 4'hc, 7'd35},
        '{8'h12, 2'd1, 4'hc, 7'd35},  '{8'h12, 2'd1, 4'h4, 7'd20}
    };

    function automatic logic [6:0] watts_lookup(input logic [7:0] sock,
                                                input logic [1:0] cores,
                                                input logic [3:0] code);
        logic [6:0] w;
        w = '0;
        for (int i = 0; i < 20; i++) begin
            if (LIMIT_TABLE[i].sock == sock && LIMIT_TABLE[i].cores == cores &&
                LIMIT_TABLE[i].code == code) begin
                w = LIMIT_TABLE[i].watts;
            end
        end
        return w;
    endfunction

    function automatic logic [12:0] mhz_of(input logic [5:0] fid);
        return 13'(fid) * 13'd100 + 13'd800;
    endfunction

    function automatic logic [10:0] volt_of(input logic [6:0] vid);
        logic [11:0] d;
        d = 12'(vid) * 12'd25;
        return (d >= 12'd1550) ? 11'd0 : 11'(12'd1550 - d);
    endfunction

endpackage

### rtl/pstg_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module pstg_div
    import pstg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int DCNT_W = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W:0]    rem_sh;

    assign rem_sh = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo = quo_reg;

endmodule

### rtl/pstate_table_generator_core.sv
// Top level of the P-state table generator: sequencer, shared multiplier and output register.
//
// Usage: a request word enters on req_valid/req_stall and is taken at an edge
// with req_valid high and req_stall low. The block then raises req_stall until
// the whole run of P-state words has left on rsp_valid/rsp_stall. Each response
// word is one P-state; the final one carries last. A request without valid or
// intermediate P-states gives a single word with empty_res set.
// Sequence: after acceptance the states DEN1, DEN2 and LOAD lie before P0 leaves.
// Each state whose power is computed passes three times through the shared
// 41x13 multiplier and then, unless the divisor is zero, through the bit-serial
// divider; copied states skip both. A full run holds at most 32 states.
// A stalled response word holds, and the sequencer waits on it.
// The user writes the socket code through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce this. Reset returns the sequencer
// to idle, drops rsp_valid and sets the socket to 0x11. There is no clearing pass.
`timescale 1ns / 1ps
module pstate_table_generator_core
    import pstg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word,
    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEN1 = 4'd1;
    localparam logic [3:0] ST_DEN2 = 4'd2;
    localparam logic [3:0] ST_LOAD = 4'd3;
    localparam logic [3:0] ST_EMIT = 4'd4;
    localparam logic [3:0] ST_P1   = 4'd5;
    localparam logic [3:0] ST_MID  = 4'd6;
    localparam logic [3:0] ST_NUM1 = 4'd7;
    localparam logic [3:0] ST_NUM2 = 4'd8;
    localparam logic [3:0] ST_NUM3 = 4'd9;
    localparam logic [3:0] ST_DIV  = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [7:0]         socket_reg, socket_next;
    logic [5:0]         max_fid_reg, max_fid_next;
    logic [5:0]         min_fid_reg, min_fid_next;
    logic [5:0]         min_vid_reg, min_vid_next;
    logic               step_reg, step_next;
    logic [16:0]        pwr0_reg, pwr0_next;
    logic [10:0]        volt0_reg, volt0_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [5:0]         fid_reg, fid_next;
    logic [6:0]         vid_reg, vid_next;
    logic [10:0]        volt_reg, volt_next;
    logic [POWER_W-1:0] pwr_reg, pwr_next;
    logic [5:0]         cur_reg, cur_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic               last_reg, last_next;
    logic [MUL_A_W-1:0] t_reg, t_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_word_t          rsp_reg, rsp_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] prod;
    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_quo;
    logic               special;
    logic [6:0]         vid0, v_tmp, drop;
    logic [12:0]        sw;

    pstg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod[NUM_W-1:0]),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_DEN1:
            begin
                mul_a = MUL_A_W'(mhz_of(fid_reg));
                mul_b = MUL_B_W'(volt0_reg);
            end
            ST_DEN2:
            begin
                mul_a = t_reg;
                mul_b = MUL_B_W'(volt0_reg);
            end
            ST_NUM1:
            begin
                mul_a = MUL_A_W'(pwr0_reg);
                mul_b = mhz_of(fid_reg);
            end
            default:
            begin
                mul_a = t_reg;
                mul_b = MUL_B_W'(volt_reg);
            end
        endcase
    end

    assign prod = (MUL_A_W + MUL_B_W)'(mul_a) * (MUL_A_W + MUL_B_W)'(mul_b);
    assign div_start = (state_reg == ST_NUM3) && (den_reg != '0);
    assign special = (req_word.max_fid == SPECIAL_FID) && (req_word.max_vid != 6'd0);
    assign vid0 = 7'(req_word.max_vid) + 7'd2;
    assign drop = max_fid_reg[0] ? 7'd1 : 7'd2;
    assign sw = {vid_reg, fid_reg};

    always_comb
    begin
        state_next = state_reg;
        socket_next = cfg_we ? cfg_wdata : socket_reg;
        max_fid_next = max_fid_reg;
        min_fid_next = min_fid_reg;
        min_vid_next = min_vid_reg;
        step_next = step_reg;
        pwr0_next = pwr0_reg;
        volt0_next = volt0_reg;
        den_next = den_reg;
        fid_next = fid_reg;
        vid_next = vid_reg;
        volt_next = volt_reg;
        pwr_next = pwr_reg;
        cur_next = cur_reg;
        n_next = n_reg;
        last_next = last_reg;
        t_next = t_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        v_tmp = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    n_next = '0;
                    if (!req_word.states_valid || !req_word.intermediate_ok)
                    begin
                        rsp_next = '0;
                        rsp_next.empty_res = 1'b1;
                        rsp_valid_next = 1'b1;
                        last_next = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        max_fid_next = req_word.max_fid;
                        min_fid_next = special ? SPECIAL_MIN_FID : req_word.low_fid;
                        min_vid_next = req_word.low_vid;
                        step_next = req_word.vid_step;
                        fid_next = special ? req_word.low_fid + 6'd10 : req_word.max_fid;
                        vid_next = vid0;
                        volt_next = volt_of(vid0);
                        volt0_next = volt_of(vid0);
                        pwr0_next = 17'(watts_lookup(socket_reg, req_word.core_cap,
                                                     req_word.power_code)) * 17'd1000;
                        pwr_next = POWER_W'(pwr0_next);
                        last_next = 1'b0;
                        state_next = ST_DEN1;
                    end
                end
            end
            ST_DEN1:
            begin
                t_next = prod[MUL_A_W-1:0];
                state_next = ST_DEN2;
            end
            ST_DEN2:
            begin
                den_next = prod[DEN_W-1:0];
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rsp_next.state_index = n_reg[4:0];
                rsp_next.fid_out = fid_reg;
                rsp_next.freq_mhz = mhz_of(fid_reg);
                rsp_next.vid_out = vid_reg;
                rsp_next.power_mw = pwr_reg;
                rsp_next.control_word = CTRL_FIXED | 32'(sw);
                rsp_next.status_word = sw;
                rsp_next.empty_res = 1'b0;
                rsp_next.last = last_reg;
                rsp_valid_next = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!rsp_stall)
                begin
                    rsp_valid_next = 1'b0;
                    n_next = n_reg + 1'b1;
                    priority if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (n_reg == '0)
                    begin
                        state_next = ST_P1;
                    end
                    else
                    begin
                        state_next = ST_MID;
                    end
                end
            end
            ST_P1:
            begin
                if ({1'b0, max_fid_reg} >= 7'(min_fid_reg) + 7'd8 + drop)
                begin
                    fid_next = max_fid_reg - drop[5:0];
                    cur_next = max_fid_reg - drop[5:0] - 6'd2;
                    if (vid_reg <= 7'(min_vid_reg))
                    begin
                        v_tmp = vid_reg + ((vid_reg[0] || !step_reg) ? 7'd1 : 7'd2);
                        vid_next = v_tmp;
                        volt_next = volt_of(v_tmp);
                        state_next = ST_NUM1;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    cur_next = max_fid_reg - 6'd2;
                    state_next = ST_MID;
                end
            end
            ST_MID:
            begin
                if (n_reg < CNT_W'(MAX_STATES - 1) &&
                    {1'b0, mhz_of(cur_reg)} >= {mhz_of(min_fid_reg), 1'b0})
                begin
                    fid_next = cur_reg;
                    cur_next = cur_reg - 6'd2;
                    if (vid_reg >= 7'(min_vid_reg))
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        v_tmp = vid_reg + (step_reg ? 7'd2 : 7'd1);
                        vid_next = v_tmp;
                        volt_next = volt_of(v_tmp);
                        state_next = ST_NUM1;
                    end
                end
                else
                begin
                    fid_next = min_fid_reg;
                    vid_next = 7'(min_vid_reg);
                    volt_next = volt_of(7'(min_vid_reg));
                    last_next = 1'b1;
                    state_next = ST_NUM1;
                end
            end
            ST_NUM1:
            begin
                t_next = prod[MUL_A_W-1:0];
                state_next = ST_NUM2;
            end
            ST_NUM2:
            begin
                t_next = prod[MUL_A_W-1:0];
                state_next = ST_NUM3;
            end
            ST_NUM3:
            begin
                if (den_reg == '0)
                begin
                    pwr_next = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    pwr_next = (div_quo[NUM_W-1:POWER_W] != '0) ? POWER_MAX
                                                                : div_quo[POWER_W-1:0];
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            socket_reg <= SOCKET_RESET;
            rsp_valid_reg <= 1'b0;
            n_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            socket_reg <= socket_next;
            rsp_valid_reg <= rsp_valid_next;
            n_reg <= n_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_fid_reg <= max_fid_next;
        min_fid_reg <= min_fid_next;
        min_vid_reg <= min_vid_next;
        step_reg <= step_next;
        pwr0_reg <= pwr0_next;
        volt0_reg <= volt0_next;
        den_reg <= den_next;
        fid_reg <= fid_next;
        vid_reg <= vid_next;
        volt_reg <= volt_next;
        pwr_reg <= pwr_next;
        cur_reg <= cur_next;
        t_reg <= t_next;
        rsp_reg <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word = rsp_reg;

    a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> state_reg == ST_EMIT)
        else $error("Response word valid outside the emit state.");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && rsp_word.last) |=> state_reg == ST_IDLE)
        else $error("Sequencer did not return to idle after the final word.");

    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_STATES))
        else $error("Run grew beyond the state limit.");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> den_reg != '0)
        else $error("Division started with a zero divisor.");

endmodule

### dv/tb_pstate_table_generator_core.sv
// Self-checking testbench for the P-state table generator core with directed and random requests.
`timescale 1ns / 1ps
module tb_pstate_table_generator_core;
    import pstg_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REQ_W = $bits(req_word_t);

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req_word = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp_word;
    logic      cfg_we = 1'b0;
    logic [7:0] cfg_wdata = '0;

    rsp_word_t pending_states[$];
    logic [7:0] socket_mirror = SOCKET_RESET;
    int mismatches = 0;
    int cycle_count = 0;
    int req_gap_max = 3;
    int stall_pct = 20;
    int long_stall = 0;

    pstate_table_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned freq_of(input int unsigned fid);
        return fid * 100 + 800;
    endfunction

    function automatic int unsigned millivolts(input int unsigned vid);
        return (vid * 25 >= 1550) ? 0 : 1550 - vid * 25;
    endfunction

    function automatic int unsigned scaled_power(input int unsigned pw0,
                                                 input int unsigned fid,
                                                 input int unsigned mv,
                                                 input longint unsigned den);
        longint unsigned num, q;
        if (den == 0)
            return 0;
        num = longint'(pw0) * freq_of(fid) * mv * mv;
        q = num / den;
        return (q > POWER_MAX) ? 32'(POWER_MAX) : 32'(q);
    endfunction

    function automatic void build_pstates(input req_word_t rq, input logic [7:0] sock,
                                          ref rsp_word_t run[$]);
        int unsigned fid_a[MAX_STATES];
        int unsigned vid_a[MAX_STATES];
        int unsigned mv_a[MAX_STATES];
        int unsigned pw_a[MAX_STATES];
        int unsigned watts, min_fid, min_vid, cur_fid, drop, step, fid;
        longint unsigned den;
        bit special;
        int n;
        rsp_word_t w;
        watts = 0;
        for (int i = 0; i < 20; i++)
        begin
            if (LIMIT_TABLE[i].sock == sock && LIMIT_TABLE[i].cores == rq.core_cap &&
                LIMIT_TABLE[i].code == rq.power_code)
            begin
                watts = LIMIT_TABLE[i].watts;
            end
        end
        if (!rq.states_valid || !rq.intermediate_ok)
        begin
            w = '0;
            w.empty_res = 1'b1;
            run.push_back(w);
            return;
        end
        step = rq.vid_step ? 2 : 1;
        special = (rq.max_fid == SPECIAL_FID) && (rq.max_vid != 0);
        min_fid = special ? 2 : rq.low_fid;
        min_vid = rq.low_vid;
        fid_a[0] = special ? ((rq.low_fid + 10) & 63) : rq.max_fid;
        vid_a[0] = (rq.max_vid + 2) & 127;
        mv_a[0] = millivolts(vid_a[0]);
        pw_a[0] = watts * 1000;
        den = longint'(freq_of(fid_a[0])) * mv_a[0] * mv_a[0];
        n = 1;
        cur_fid = rq.max_fid;
        drop = rq.max_fid[0] ? 1 : 2;
        if (int'(rq.max_fid) - int'(drop) >= int'(min_fid) + 8)
        begin
            fid_a[1] = rq.max_fid - drop;
            cur_fid = fid_a[1];
            if (int'(vid_a[0]) - 1 < int'(min_vid))
            begin
                vid_a[1] = (vid_a[0] + (vid_a[0][0] ? 1 : step)) & 127;
                mv_a[1] = millivolts(vid_a[1]);
                pw_a[1] = scaled_power(pw_a[0], fid_a[1], mv_a[1], den);
            end
            else
            begin
                vid_a[1] = vid_a[0];
                mv_a[1] = mv_a[0];
                pw_a[1] = pw_a[0];
            end
            n = 2;
        end
        cur_fid = (cur_fid - 2) & 63;
        while (n < MAX_STATES - 1 && freq_of(cur_fid) >= freq_of(min_fid) * 2)
        begin
            fid = cur_fid;
            cur_fid = (cur_fid - 2) & 63;
            fid_a[n] = fid;
            if (vid_a[n-1] >= min_vid)
            begin
                vid_a[n] = vid_a[n-1];
                mv_a[n] = mv_a[n-1];
                pw_a[n] = pw_a[n-1];
            end
            else
            begin
                vid_a[n] = (vid_a[n-1] + step) & 127;
                mv_a[n] = millivolts(vid_a[n]);
                pw_a[n] = scaled_power(pw_a[0], fid_a[n], mv_a[n], den);
            end
            n++;
        end
        fid_a[n] = special ? 2 : rq.low_fid;
        vid_a[n] = min_vid;
        mv_a[n] = millivolts(vid_a[n]);
        pw_a[n] = scaled_power(pw_a[0], fid_a[n], mv_a[n], den);
        n++;
        for (int i = 0; i < n; i++)
        begin
            w = '0;
            w.state_index = i[4:0];
            w.fid_out = fid_a[i][5:0];
            w.freq_mhz = 13'(freq_of(fid_a[i]));
            w.vid_out = vid_a[i][6:0];
            w.power_mw = 20'(pw_a[i]);
            w.status_word = 13'((vid_a[i] << 6) | fid_a[i]);
            w.control_word = CTRL_FIXED | ((vid_a[i] << 6) | fid_a[i]);
            w.last = (i == n - 1);
            run.push_back(w);
        end
    endfunction

    always @(negedge clk)
    begin
        if (long_stall > 0)
        begin
            long_stall <= long_stall - 1;
            rsp_stall <= 1'b1;
        end
        else if ($urandom_range(0, 199) == 0)
        begin
            long_stall <= $urandom_range(20, 60);
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_states.size() == 0)
            begin
                $error("unexpected word %h", rsp_word);
                mismatches++;
            end
            else
            begin
                rsp_word_t e;
                e = pending_states.pop_front();
                if (rsp_word.state_index !== e.state_index)
                    $error("state_index exp %0d got %0d", e.state_index, rsp_word.state_index);
                if (rsp_word.fid_out !== e.fid_out)
                    $error("fid_out exp %0d got %0d", e.fid_out, rsp_word.fid_out);
                if (rsp_word.freq_mhz !== e.freq_mhz)
                    $error("freq_mhz exp %0d got %0d", e.freq_mhz, rsp_word.freq_mhz);
                if (rsp_word.vid_out !== e.vid_out)
                    $error("vid_out exp %0d got %0d", e.vid_out, rsp_word.vid_out);
                if (rsp_word.power_mw !== e.power_mw)
                    $error("power_mw exp %0d got %0d", e.power_mw, rsp_word.power_mw);
                if (rsp_word.control_word !== e.control_word)
                    $error("control_word exp %h got %h", e.control_word, rsp_word.control_word);
                if (rsp_word.status_word !== e.status_word)
                    $error("status_word exp %h got %h", e.status_word, rsp_word.status_word);
                if (rsp_word.empty_res !== e.empty_res)
                    $error("empty_res exp %0d got %0d", e.empty_res, rsp_word.empty_res);
                if (rsp_word.last !== e.last)
                    $error("last exp %0d got %0d", e.last, rsp_word.last);
                if (rsp_word !== e)
                    mismatches++;
            end
        end
    end

    task automatic send_req(input req_word_t w);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, req_gap_max);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_word <= w;
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
        end
        build_pstates(w, socket_mirror, pending_states);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (pending_states.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_socket(input logic [7:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        socket_mirror = v;
    endtask

    function automatic req_word_t mk_req(input int cores, input int code, input int sv,
                                         input int io, input int mf, input int sf,
                                         input int mv, input int sv2, input int st);
        req_word_t r;
        r.core_cap = 2'(cores);
        r.power_code = 4'(code);
        r.states_valid = 1'(sv);
        r.intermediate_ok = 1'(io);
        r.max_fid = 6'(mf);
        r.low_fid = 6'(sf);
        r.max_vid = 6'(mv);
        r.low_vid = 6'(sv2);
        r.vid_step = 1'(st);
        return r;
    endfunction

    function automatic req_word_t rand_req();
        req_word_t r;
        r = req_word_t'(REQ_W'({$urandom, $urandom}));
        if ($urandom_range(0, 9) < 8)
        begin
            r.states_valid = 1'b1;
            r.intermediate_ok = 1'b1;
        end
        if ($urandom_range(0, 3) != 0)
            r.core_cap = 2'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            r.max_fid = SPECIAL_FID;
        return r;
    endfunction

    task automatic test_empty_runs();
        send_req(mk_req(0, 8, 0, 1, 20, 4, 10, 20, 0));
        send_req(mk_req(1, 8, 1, 0, 20, 4, 10, 20, 1));
        send_req(mk_req(3, 15, 0, 0, 63, 63, 63, 63, 1));
    endtask

    task automatic test_directed_runs();
        send_req(mk_req(1, 12, 1, 1, 63, 0, 0, 63, 1));
        send_req(mk_req(0, 0, 1, 1, 0, 0, 0, 0, 0));
        send_req(mk_req(3, 15, 1, 1, 63, 63, 63, 63, 1));
        send_req(mk_req(0, 8, 1, 1, 42, 60, 5, 20, 0));
        send_req(mk_req(1, 10, 1, 1, 42, 3, 0, 20, 1));
        send_req(mk_req(1, 7, 1, 1, 30, 4, 4, 40, 0));
        send_req(mk_req(1, 7, 1, 1, 31, 4, 5, 40, 1));
        send_req(mk_req(1, 6, 1, 1, 30, 4, 30, 2, 0));
        send_req(mk_req(0, 5, 1, 1, 40, 2, 62, 63, 1));
        send_req(mk_req(1, 1, 1, 1, 50, 1, 61, 10, 0));
        send_req(mk_req(0, 2, 1, 1, 1, 40, 10, 50, 1));
    endtask

    task automatic test_hold_off();
        send_req(mk_req(1, 8, 1, 1, 25, 5, 8, 30, 0));
        @(negedge clk);
        req_valid <= 1'b0;
        wait (pending_states.size() == 0);
        send_req(mk_req(0, 4, 1, 1, 25, 5, 8, 30, 1));
    endtask

    task automatic test_socket_settings();
        logic [7:0] socks[4];
        socks = '{8'h12, 8'h00, 8'hFF, SOCKET_RESET};
        foreach (socks[s])
        begin
            write_socket(socks[s]);
            send_req(mk_req(0, 12, 1, 1, 30, 4, 10, 30, 0));
            send_req(mk_req(1, 4, 1, 1, 30, 4, 10, 30, 1));
            send_req(mk_req(0, 8, 1, 1, 30, 4, 10, 30, 0));
        end
    endtask

    task automatic test_random_runs();
        for (int i = 0; i < 112; i++)
        begin
            if (i % 28 == 0)
            begin
                stall_pct = (i % 56 == 0) ? 0 : 50;
                req_gap_max = (i % 56 == 0) ? 0 : 6;
            end
            if (i == 56)
                write_socket(8'h12);
            if (i == 84)
                write_socket(SOCKET_RESET);
            send_req(rand_req());
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_empty_runs();
        test_directed_runs();
        test_hold_off();
        test_socket_settings();
        test_random_runs();
        drain();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
